// ----- hdl/ffca_pkg.sv -----
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants for the first-fit coalescing allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int unsigned POOL_GRANULES_DEF = 1024;
    localparam int unsigned GRANULE_BYTES_DEF = 32;
    localparam int unsigned CTRL_AREA_BYTES   = 256;
    localparam int unsigned ADDR_W            = 26;
    localparam int unsigned SIZE_W            = 16;
    localparam int unsigned CFG_W             = 26;
    localparam int unsigned POOL_CFG_W        = 11;
    localparam int unsigned POOL_RESET        = 1024;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_NOTALLOC = 2'd3;

    localparam logic [0:0] REG_POOL = 1'b0;
    localparam logic [0:0] REG_BASE = 1'b1;

    localparam logic [0:0] ACT_ALLOC = 1'b0;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_FREE = 2'd1,
        K_USED = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WALK_RD,
        S_WALK_EV,
        S_ALLOC_WR,
        S_FREE_RDN,
        S_FREE_EVN,
        S_FREE_RDP,
        S_FREE_EVP,
        S_OUT
    } t_state;

    // Request, result and register write payloads.
    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
    } t_rsp;

    typedef struct packed {
        logic [0:0]       index;
        logic [CFG_W-1:0] value;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_start;
        logic clear_step;
        logic load;
        logic walk_start;
        logic rd_cur;
        logic eval_walk;
        logic alloc_write;
        logic rd_next;
        logic eval_next;
        logic rd_prev;
        logic eval_prev;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic is_alloc;
        logic early_done;
        logic walk_done;
    } t_stat;

endpackage

// ----- hdl/ffca_if.sv -----
// ----------------------------------------------------------------------------
// ffca_if
// Valid/ready channel carrying one payload type.
// ----------------------------------------------------------------------------
interface ffca_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/first_fit_coalescing_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_core
// First-fit granule allocator with split and two-sided coalescing.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate walks every block header
// from granule 1 to the pool end, then writes the chosen header (and the
// split remainder); a free walks up to its own header, then reads and
// merges the next and previous neighbors. A request rejected at decode
// goes straight to the result. Every block spans at least two granules,
// and the walk reads one header at a time. After reset and after every
// pool_granules write, all POOL_GRANULES entries of the header memory are
// cleared one entry per cycle, and no request beat is accepted until the
// clear is done. The result beat is held in an output register until
// taken, and no new request is accepted while it waits.
module first_fit_coalescing_allocator_core #(
    parameter int unsigned POOL_GRANULES = ffca_pkg::POOL_GRANULES_DEF,
    parameter int unsigned GRANULE_BYTES = ffca_pkg::GRANULE_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ffca_if.sink   in_ch,
    ffca_if.source out_ch,
    ffca_if.sink   cfg_ch
);
    localparam int unsigned GW = $clog2(POOL_GRANULES + 1);

    ffca_pkg::t_cmd   cmd;
    ffca_pkg::t_stat  stat;
    ffca_pkg::t_state state;
    logic             in_ready;
    logic             r_out_valid;
    logic [GW-1:0]    r_pool_n;
    logic [ffca_pkg::ADDR_W-1:0] r_dma_base;
    logic             rebuild;
    logic [GW-1:0]    pool_wr;
    logic [1:0]       status;
    logic [ffca_pkg::ADDR_W-1:0] addr;

    assign cfg_ch.ready = 1'b1;
    assign rebuild = cfg_ch.valid && cfg_ch.data.index == ffca_pkg::REG_POOL;

    always_comb begin
        if (cfg_ch.data.value[10:0] < 11'd3) begin
            pool_wr = GW'(3);
        end else if (32'(cfg_ch.data.value[10:0]) > POOL_GRANULES) begin
            pool_wr = GW'(POOL_GRANULES);
        end else begin
            pool_wr = GW'(cfg_ch.data.value[10:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_n   <= (POOL_GRANULES < ffca_pkg::POOL_RESET) ?
                          GW'(POOL_GRANULES) : GW'(ffca_pkg::POOL_RESET);
            r_dma_base <= '0;
        end else if (cfg_ch.valid) begin
            if (cfg_ch.data.index == ffca_pkg::REG_POOL) begin
                r_pool_n <= pool_wr;
            end else begin
                r_dma_base <= cfg_ch.data.value;
            end
        end
    end

    ffca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_out_busy (r_out_valid),
        .i_rebuild  (rebuild),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (in_ready),
        .o_state    (state)
    );

    ffca_dp #(
        .POOL_GRANULES (POOL_GRANULES),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (in_ch.data.action),
        .i_size_bytes (in_ch.data.size_bytes),
        .i_free_addr  (in_ch.data.free_addr),
        .i_pool_n     (r_pool_n),
        .i_dma_base   (r_dma_base),
        .o_status     (status),
        .o_addr       (addr)
    );

    assign in_ch.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign out_ch.valid           = r_out_valid;
    assign out_ch.data.status     = status;
    assign out_ch.data.addr       = addr;

`ifndef SYNTH
    // A result is only produced by the output step of the sequencer.
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(state == ffca_pkg::S_OUT))
        else $error("result without output step");
    // No request is taken while a result waits.
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !in_ch.ready)
        else $error("input taken while output pending");
    // Requests are taken only in the idle state.
    a_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> state == ffca_pkg::S_IDLE)
        else $error("ready outside idle");
`endif

endmodule

// ----- hdl/ffca_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer for clearing, the header walk, the split and the merges.
// ----------------------------------------------------------------------------
module ffca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_busy,
    input  logic            i_rebuild,
    input  ffca_pkg::t_stat i_stat,
    output ffca_pkg::t_cmd  o_cmd,
    output logic            o_in_ready,
    output ffca_pkg::t_state o_state
);
    ffca_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffca_pkg::S_CLEAR;
        end else if (i_rebuild) begin
            r_state <= ffca_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ffca_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = ffca_pkg::S_IDLE;
                end
            end
            ffca_pkg::S_IDLE: begin
                o_in_ready = !i_out_busy;
                if (i_in_valid && !i_out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = ffca_pkg::S_DECODE;
                end
            end
            ffca_pkg::S_DECODE: begin
                if (i_stat.early_done) begin
                    n_state = ffca_pkg::S_OUT;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = ffca_pkg::S_WALK_RD;
                end
            end
            ffca_pkg::S_WALK_RD: begin
                if (i_stat.walk_done) begin
                    if (i_stat.is_alloc) begin
                        n_state = ffca_pkg::S_ALLOC_WR;
                    end else if (i_stat.early_done) begin
                        // A rejected free leaves the store untouched.
                        n_state = ffca_pkg::S_OUT;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = ffca_pkg::S_FREE_EVN;
                    end
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = ffca_pkg::S_WALK_EV;
                end
            end
            ffca_pkg::S_WALK_EV: begin
                o_cmd.eval_walk = 1'b1;
                n_state         = ffca_pkg::S_WALK_RD;
            end
            ffca_pkg::S_ALLOC_WR: begin
                o_cmd.alloc_write = 1'b1;
                n_state           = ffca_pkg::S_OUT;
            end
            ffca_pkg::S_FREE_EVN: begin
                o_cmd.eval_next = 1'b1;
                n_state         = ffca_pkg::S_FREE_RDP;
            end
            ffca_pkg::S_FREE_RDP: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = ffca_pkg::S_FREE_EVP;
            end
            ffca_pkg::S_FREE_EVP: begin
                o_cmd.eval_prev = 1'b1;
                n_state         = ffca_pkg::S_OUT;
            end
            ffca_pkg::S_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state        = ffca_pkg::S_IDLE;
            end
            default: begin
                n_state = ffca_pkg::S_CLEAR;
            end
        endcase
        if (i_rebuild) begin
            o_cmd.clear_start = 1'b1;
        end
    end

    assign o_state = r_state;

endmodule

// ----- hdl/ffca_dp.sv -----
// ----------------------------------------------------------------------------
// ffca_dp
// Header memory, walk registers, request decode and result formation.
// ----------------------------------------------------------------------------
module ffca_dp #(
    parameter int unsigned POOL_GRANULES = ffca_pkg::POOL_GRANULES_DEF,
    parameter int unsigned GRANULE_BYTES = ffca_pkg::GRANULE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffca_pkg::t_cmd              i_cmd,
    output ffca_pkg::t_stat             o_stat,
    input  logic                        i_action,
    input  logic [ffca_pkg::SIZE_W-1:0] i_size_bytes,
    input  logic [ffca_pkg::ADDR_W-1:0] i_free_addr,
    input  logic [$clog2(POOL_GRANULES+1)-1:0] i_pool_n,
    input  logic [ffca_pkg::ADDR_W-1:0] i_dma_base,
    output logic [1:0]                  o_status,
    output logic [ffca_pkg::ADDR_W-1:0] o_addr
);
    localparam int unsigned GW = $clog2(POOL_GRANULES + 1);
    localparam int unsigned IW = $clog2(POOL_GRANULES);
    localparam int unsigned SH = $clog2(GRANULE_BYTES);
    localparam int unsigned AW = ffca_pkg::ADDR_W;
    localparam int unsigned EW = 2 + GW;

    // Memory: each entry holds a kind and a data length.
    logic [EW-1:0] mem [POOL_GRANULES];
    logic [EW-1:0] r_rd;
    logic [IW-1:0] rd_a, wr_a;
    logic [EW-1:0] wr_d;
    logic          wr_en;
    logic [IW-1:0] wr2_a;
    logic [EW-1:0] wr2_d;
    logic          wr2_en;

    logic [GW-1:0] r_clr;
    logic          r_act;
    logic [GW-1:0] r_need;
    logic [GW-1:0] r_g, r_hit, r_prev, r_h, r_hlen;
    logic [GW-1:0] r_hitlen;
    logic [GW-1:0] r_nfree;
    logic          r_hit_ok;
    logic [1:0]    r_st;
    logic [GW-1:0] res_g;

    ffca_pkg::t_kind rd_kind;
    logic [GW-1:0]   rd_len;
    assign rd_kind = ffca_pkg::t_kind'(r_rd[EW-1:GW]);
    assign rd_len  = r_rd[GW-1:0];

    logic [GW:0]    nxt_sum;
    logic [AW-1:0]  off;
    logic [AW-SH-1:0] idx_w;
    logic           idx_ok;
    logic [16:0]    need_w;

    assign need_w  = (17'(i_size_bytes) + 17'(GRANULE_BYTES - 1)) >> SH;
    assign off     = i_free_addr - i_dma_base - AW'(ffca_pkg::CTRL_AREA_BYTES);
    assign idx_w   = off[AW-1:SH];
    assign idx_ok  = (idx_w >= (AW-SH)'(2)) && (idx_w < (AW-SH)'(i_pool_n));
    assign nxt_sum = (GW+1)'(r_g) + (GW+1)'(rd_len) + (GW+1)'(1);

    // Read address choice.
    always_comb begin
        rd_a = r_g[IW-1:0];
        if (i_cmd.rd_next) begin
            rd_a = IW'((GW+1)'(r_h) + (GW+1)'(r_hlen) + (GW+1)'(1));
        end else if (i_cmd.rd_prev) begin
            rd_a = r_prev[IW-1:0];
        end
    end

    logic r_walk_end;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_a] <= wr_d;
        end
        if (wr2_en) begin
            mem[wr2_a] <= wr2_d;
        end
        r_rd <= mem[rd_a];
    end

    // Write port selection (two writes are used in the split step and in the merges).
    logic [GW:0] rest_g, nxt_g;
    assign rest_g = (GW+1)'(r_hit) + (GW+1)'(r_need) + (GW+1)'(1);
    assign nxt_g  = (GW+1)'(r_h) + (GW+1)'(r_hlen) + (GW+1)'(1);
    logic split;
    assign split = (r_hitlen > GW'((GW+1)'(r_need) + (GW+1)'(1)));

    // No fit at all, or a fit that would take the last free block whole.
    logic alloc_refuse;
    assign alloc_refuse = !r_hit_ok || (!split && r_nfree == GW'(1));

    logic nxt_free, prev_free;
    logic [GW-1:0] merged_len;
    assign nxt_free  = (nxt_g < (GW+1)'(i_pool_n)) && (rd_kind == ffca_pkg::K_FREE);
    assign prev_free = (r_prev != '0) && (rd_kind == ffca_pkg::K_FREE);

    always_comb begin
        wr_en  = 1'b0;
        wr_a   = r_clr[IW-1:0];
        wr_d   = '0;
        wr2_en = 1'b0;
        wr2_a  = rest_g[IW-1:0];
        wr2_d  = {ffca_pkg::K_FREE, GW'(r_hitlen - r_need - GW'(1))};
        merged_len = r_hlen + GW'(1) + rd_len;
        if (i_cmd.clear_step) begin
            wr_en = 1'b1;
            wr_a  = r_clr[IW-1:0];
            if (r_clr == GW'(1)) begin
                wr_d = {ffca_pkg::K_FREE, GW'(i_pool_n - GW'(2))};
            end
        end else if (i_cmd.alloc_write && r_st == ffca_pkg::ST_OK && !alloc_refuse) begin
            wr_en = 1'b1;
            wr_a  = r_hit[IW-1:0];
            wr_d  = {ffca_pkg::K_USED, split ? r_need : r_hitlen};
            wr2_en = split;
        end else if (i_cmd.eval_next) begin
            wr_en = 1'b1;
            wr_a  = r_h[IW-1:0];
            wr_d  = {ffca_pkg::K_FREE, nxt_free ? merged_len : r_hlen};
            if (nxt_free) begin
                wr2_en = 1'b1;
                wr2_a  = nxt_g[IW-1:0];
                wr2_d  = '0;
            end
        end else if (i_cmd.eval_prev && prev_free) begin
            wr_en  = 1'b1;
            wr_a   = r_prev[IW-1:0];
            wr_d   = {ffca_pkg::K_FREE, GW'(rd_len + GW'(1) + r_hlen)};
            wr2_en = 1'b1;
            wr2_a  = r_h[IW-1:0];
            wr2_d  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_start) begin
            r_clr <= '0;
        end else if (i_cmd.clear_step && !o_stat.clear_done) begin
            r_clr <= r_clr + GW'(1);
        end
    end
    assign o_stat.clear_done = (r_clr == GW'(POOL_GRANULES - 1));

    // Request and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_action;
            r_need   <= GW'(need_w);
            r_st     <= ffca_pkg::ST_OK;
            r_h      <= GW'(idx_w - (AW-SH)'(1));
            r_hit_ok <= 1'b0;
            if (i_action == ffca_pkg::ACT_ALLOC) begin
                if (i_size_bytes == '0) begin
                    r_st <= ffca_pkg::ST_NULL;
                end else if (need_w > 17'(POOL_GRANULES)) begin
                    r_st <= ffca_pkg::ST_NOSPACE;
                end
            end else if (i_free_addr == '0) begin
                r_st <= ffca_pkg::ST_NULL;
            end else if (off[SH-1:0] != '0 || !idx_ok) begin
                r_st <= ffca_pkg::ST_NOTALLOC;
            end
        end
        if (i_cmd.walk_start) begin
            r_g      <= GW'(1);
            r_prev   <= '0;
            r_nfree  <= '0;
            r_hit    <= '0;
            r_hitlen <= '0;
            r_hlen   <= '0;
            r_walk_end <= 1'b0;
        end
        if (i_cmd.eval_walk) begin
            if (r_act == ffca_pkg::ACT_ALLOC) begin
                if (rd_kind == ffca_pkg::K_FREE) begin
                    r_nfree <= (r_nfree == GW'(2)) ? r_nfree : r_nfree + GW'(1);
                    if (!r_hit_ok && rd_len >= r_need) begin
                        r_hit_ok <= 1'b1;
                        r_hit    <= r_g;
                        r_hitlen <= rd_len;
                    end
                end
            end else begin
                if (r_g == r_h) begin
                    r_hlen     <= rd_len;
                    r_walk_end <= 1'b1;
                    if (rd_kind != ffca_pkg::K_USED) begin
                        r_st <= ffca_pkg::ST_NOTALLOC;
                    end
                end else begin
                    if (r_g < r_h) begin
                        r_prev <= r_g;
                    end
                    // The walk stepped over the address or ran off the pool:
                    // the address does not start a block.
                    if (r_g > r_h || nxt_sum >= (GW+1)'(i_pool_n)) begin
                        r_st <= ffca_pkg::ST_NOTALLOC;
                    end
                end
            end
            if (nxt_sum >= (GW+1)'(i_pool_n) ||
                (r_act != ffca_pkg::ACT_ALLOC && r_g >= r_h)) begin
                r_walk_end <= 1'b1;
            end
            r_g <= GW'(nxt_sum);
        end
        if (i_cmd.alloc_write) begin
            if (alloc_refuse) begin
                r_st <= ffca_pkg::ST_NOSPACE;
            end
        end
        if (i_cmd.eval_next && nxt_free) begin
            r_hlen <= merged_len;
        end
    end

    assign o_stat.is_alloc   = (r_act == ffca_pkg::ACT_ALLOC);
    assign o_stat.early_done = (r_st != ffca_pkg::ST_OK);
    assign o_stat.walk_done  = r_walk_end || (r_act != ffca_pkg::ACT_ALLOC &&
                                r_st != ffca_pkg::ST_OK);

    assign res_g = r_hit + GW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status <= r_st;
            if (r_st == ffca_pkg::ST_OK && r_act == ffca_pkg::ACT_ALLOC) begin
                o_addr <= i_dma_base + AW'(ffca_pkg::CTRL_AREA_BYTES) +
                          (AW'(res_g) << SH);
            end else begin
                o_addr <= '0;
            end
        end
    end

endmodule
